// ===== design/pllp_pkg.sv =====
package pllp_pkg;

  // defaults for the top-level parameters
  localparam int unsigned POOL_DEPTH_DEF = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // fixed field widths of the stream beats
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  localparam int unsigned IN_DATA_W  = 40;  // position + value, padded to bytes
  localparam int unsigned OUT_DATA_W = 40;  // read_value + count + empty_res

  // operation codes
  localparam logic [MODE_W-1:0] MODE_FETCH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STORE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PAST_END = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;           // take the input beat, start at the front
    logic walk_step;      // follow one next link
    logic walk_end;       // settle on the current node
    logic dispatch;       // latch the operation status
    logic rd_val;         // read data word of the node
    logic rd_prev;        // read prev link of the node
    logic rd_next_node;   // read next link of the node
    logic rd_next_fresh;  // read next link of the free stack top
    logic wr_val;         // overwrite data word of the node
    logic ins_a;          // fill the fresh node, pop the free stack
    logic ins_b;          // hook the fresh node into its neighbors
    logic del_a;          // unhook the node from its neighbors
    logic del_b;          // push the node onto the free stack
    logic emit;           // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic              walk_done;
    logic              node_sent;
    logic              pool_full;
    logic              out_free;
    logic [MODE_W-1:0] mode;
  } sts_t;

endpackage

// ===== design/pllp_ctrl.sv =====
module pllp_ctrl
  import pllp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_WALK     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_INS_A    = 4'd3;
  localparam logic [3:0] S_INS_B    = 4'd4;
  localparam logic [3:0] S_DEL_A    = 4'd5;
  localparam logic [3:0] S_DEL_B    = 4'd6;
  localparam logic [3:0] S_DONE     = 4'd7;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_WALK;
        end
      end
      S_WALK: begin
        if (sts_i.walk_done) begin
          cmd_o.walk_end = 1'b1;
          state_d        = S_DISPATCH;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_DISPATCH: begin
        cmd_o.dispatch = 1'b1;
        state_d        = S_DONE;
        if (sts_i.mode == MODE_INSERT) begin
          if (!sts_i.pool_full) begin
            cmd_o.rd_prev       = 1'b1;
            cmd_o.rd_next_fresh = 1'b1;
            state_d             = S_INS_A;
          end
        end else if (!sts_i.node_sent) begin
          case (sts_i.mode)
            MODE_FETCH: cmd_o.rd_val = 1'b1;
            MODE_STORE: cmd_o.wr_val = 1'b1;
            MODE_DELETE: begin
              cmd_o.rd_prev      = 1'b1;
              cmd_o.rd_next_node = 1'b1;
              state_d            = S_DEL_A;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_INS_A: begin
        cmd_o.ins_a = 1'b1;
        state_d     = S_INS_B;
      end
      S_INS_B: begin
        cmd_o.ins_b = 1'b1;
        state_d     = S_DONE;
      end
      S_DEL_A: begin
        cmd_o.del_a = 1'b1;
        state_d     = S_DEL_B;
      end
      S_DEL_B: begin
        cmd_o.del_b = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/pllp_dpath.sv =====
module pllp_dpath
  import pllp_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic [MODE_W-1:0]     in_mode_i,
  input  logic [POS_W-1:0]      in_position_i,
  input  logic [VALUE_W-1:0]    in_value_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic [STATUS_W-1:0]   out_status_o
);

  localparam int unsigned LW = $clog2(POOL_DEPTH + 1);  // link incl. sentinel
  localparam int unsigned AW = $clog2(POOL_DEPTH);      // pool address
  localparam logic [LW-1:0] SENT = LW'(POOL_DEPTH);

  logic [DATA_WIDTH-1:0] val_mem  [POOL_DEPTH];
  logic [LW-1:0]         next_mem [POOL_DEPTH];
  logic [LW-1:0]         prev_mem [POOL_DEPTH];

  // sentinel links, free stack and fill mark of the never-used nodes
  logic [LW-1:0] head_q, tail_q, free_top_q, fill_q, count_q;

  logic [LW-1:0]         node_q, fresh_q, before_q;
  logic [POS_W-1:0]      steps_q;
  logic                  fwd_q;
  logic [MODE_W-1:0]     mode_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [STATUS_W-1:0]   st_q;
  logic [LW-1:0]         nrd_q, prd_q;
  logic [DATA_WIDTH-1:0] vrd_q;

  logic                  out_valid_q;
  logic [VALUE_W-1:0]    out_rd_q;
  logic [COUNT_W-1:0]    out_cnt_q;
  logic                  out_empty_q;
  logic [STATUS_W-1:0]   out_st_q;

  logic [LW-1:0] cur_node, ins_before, free_next;
  logic          fresh_untouched;

  // during the walk the next node comes straight from the link read
  assign cur_node        = fwd_q ? nrd_q : node_q;
  assign ins_before      = (node_q == SENT) ? tail_q : prd_q;
  assign fresh_untouched = (free_top_q == fill_q);
  assign free_next       = fresh_untouched ? (fill_q + LW'(1)) : nrd_q;

  assign sts_o.walk_done = (steps_q == '0) || (cur_node == SENT);
  assign sts_o.node_sent = (node_q == SENT);
  assign sts_o.pool_full = (free_top_q == SENT);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.mode      = mode_q;

  // memory port selection
  logic          val_we;
  logic [AW-1:0] val_waddr;
  logic          next_we, next_re;
  logic [AW-1:0] next_waddr, next_raddr;
  logic [LW-1:0] next_wdata;
  logic          prev_we;
  logic [AW-1:0] prev_waddr;
  logic [LW-1:0] prev_wdata;

  always_comb begin
    val_we    = cmd_i.ins_a || cmd_i.wr_val;
    val_waddr = cmd_i.ins_a ? free_top_q[AW-1:0] : node_q[AW-1:0];

    next_we    = 1'b0;
    next_waddr = node_q[AW-1:0];
    next_wdata = free_top_q;
    if (cmd_i.ins_a) begin
      next_we    = 1'b1;
      next_waddr = free_top_q[AW-1:0];
      next_wdata = node_q;
    end else if (cmd_i.ins_b) begin
      next_we    = (before_q != SENT);
      next_waddr = before_q[AW-1:0];
      next_wdata = fresh_q;
    end else if (cmd_i.del_a) begin
      next_we    = (prd_q != SENT);
      next_waddr = prd_q[AW-1:0];
      next_wdata = nrd_q;
    end else if (cmd_i.del_b) begin
      next_we = 1'b1;
    end

    next_re    = cmd_i.walk_step || cmd_i.rd_next_fresh || cmd_i.rd_next_node;
    next_raddr = node_q[AW-1:0];
    if (cmd_i.walk_step) begin
      next_raddr = cur_node[AW-1:0];
    end else if (cmd_i.rd_next_fresh) begin
      next_raddr = free_top_q[AW-1:0];
    end

    prev_we    = 1'b0;
    prev_waddr = free_top_q[AW-1:0];
    prev_wdata = ins_before;
    if (cmd_i.ins_a) begin
      prev_we = 1'b1;
    end else if (cmd_i.ins_b) begin
      prev_we    = (node_q != SENT);
      prev_waddr = node_q[AW-1:0];
      prev_wdata = fresh_q;
    end else if (cmd_i.del_a) begin
      prev_we    = (nrd_q != SENT);
      prev_waddr = nrd_q[AW-1:0];
      prev_wdata = prd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_q;
    end
    if (cmd_i.rd_val) begin
      vrd_q <= val_mem[node_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (next_re) begin
      nrd_q <= next_mem[next_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (cmd_i.rd_prev) begin
      prd_q <= prev_mem[node_q[AW-1:0]];
    end
  end

  // list bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= SENT;
      tail_q     <= SENT;
      free_top_q <= '0;
      fill_q     <= '0;
      count_q    <= '0;
      fwd_q      <= 1'b0;
    end else begin
      if (cmd_i.load || cmd_i.walk_end) begin
        fwd_q <= 1'b0;
      end else if (cmd_i.walk_step) begin
        fwd_q <= 1'b1;
      end
      if (cmd_i.ins_a) begin
        free_top_q <= free_next;
        if (fresh_untouched) begin
          fill_q <= fill_q + LW'(1);
        end
      end
      if (cmd_i.ins_b) begin
        if (before_q == SENT) begin
          head_q <= fresh_q;
        end
        if (node_q == SENT) begin
          tail_q <= fresh_q;
        end
        count_q <= count_q + LW'(1);
      end
      if (cmd_i.del_a) begin
        if (nrd_q == SENT) begin
          tail_q <= prd_q;
        end
        if (prd_q == SENT) begin
          head_q <= nrd_q;
        end
      end
      if (cmd_i.del_b) begin
        free_top_q <= node_q;
        if (count_q != '0) begin
          count_q <= count_q - LW'(1);
        end
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= in_mode_i;
      val_q   <= DATA_WIDTH'(in_value_i);
      node_q  <= head_q;
      steps_q <= (in_position_i > POS_W'(1)) ? (in_position_i - POS_W'(1)) : '0;
    end
    if (cmd_i.walk_step) begin
      node_q  <= cur_node;
      steps_q <= steps_q - POS_W'(1);
    end
    if (cmd_i.walk_end) begin
      node_q <= cur_node;
    end
    if (cmd_i.dispatch) begin
      if (mode_q == MODE_INSERT) begin
        st_q <= (free_top_q == SENT) ? ST_FULL : ST_OK;
      end else begin
        st_q <= (node_q == SENT) ? ST_PAST_END : ST_OK;
      end
    end
    if (cmd_i.ins_a) begin
      fresh_q  <= free_top_q;
      before_q <= ins_before;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_rd_q    <= (mode_q == MODE_FETCH && st_q == ST_OK) ? VALUE_W'(vrd_q) : '0;
      out_cnt_q   <= COUNT_W'(count_q);
      out_empty_q <= (count_q == '0);
      out_st_q    <= st_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = {out_empty_q, out_cnt_q, out_rd_q};
  assign out_status_o = out_st_q;

endmodule

// ===== design/pooled_linked_list_by_position.sv =====
// Doubly linked list kept in a pool of POOL_DEPTH nodes, addressed by 1-based position
// (0 and 1 both select the first element). Each input beat fetches, stores, inserts before
// or deletes the element at its position and gives one output beat with the read word,
// a status (ok, past end, pool full), the element count and an empty flag. The node is
// found by following next links from the front, one link per cycle through the link
// memory's registered read port, stopping early at the end of the list; the walk follows
// max(position-1, 0) links, never more than the element count. Items are taken one at a
// time, and an item is held up while a finished output beat still waits for m_axis_tready.
// Free nodes sit on a stack; nodes never used since reset are handed out in order through
// a fill mark, so no clearing pass follows reset.
module pooled_linked_list_by_position
  import pllp_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // position[6:0], value[38:7], zero pad
  input  logic [MODE_W-1:0]     s_axis_tuser,   // mode[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // read_value[31:0], count[38:32], empty_res[39]
  output logic [STATUS_W-1:0]   m_axis_tuser    // status[1:0]
);

  cmd_t cmd;
  sts_t sts;

  pllp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pllp_dpath #(
    .POOL_DEPTH (POOL_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_mode_i     (s_axis_tuser),
    .in_position_i (s_axis_tdata[POS_W-1:0]),
    .in_value_i    (s_axis_tdata[POS_W+VALUE_W-1:POS_W]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_data_o    (m_axis_tdata),
    .out_status_o  (m_axis_tuser)
  );

endmodule
